FILE: src/fscd_pkg.sv
package fscd_pkg;

  localparam int MaxFrameDef = 7;
  localparam int MaxFrameHi  = 16;
  localparam int PosW        = $clog2(MaxFrameHi + 1);
  localparam int QueueDepth  = 4;
  localparam int DelayW      = 20;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  localparam logic [DelayW-1:0] DelayCap = 20'd999999;

  localparam logic [7:0]  StartMarkerRst  = 8'd2;
  localparam logic [7:0]  EndMarkerRst    = 8'd3;
  localparam logic [15:0] DefaultDelayRst = 16'd250;
  localparam logic [15:0] QuickDelayRst   = 16'd50;

  localparam logic [7:0] ChS    = "S";
  localparam logic [7:0] ChC    = "C";
  localparam logic [7:0] ChR    = "R";
  localparam logic [7:0] ChW    = "W";
  localparam logic [7:0] ChL    = "L";
  localparam logic [7:0] ChUp   = "U";
  localparam logic [7:0] ChUpQ  = "u";
  localparam logic [7:0] ChDn   = "D";
  localparam logic [7:0] ChDnQ  = "d";
  localparam logic [7:0] ChMy   = "M";
  localparam logic [7:0] ChMyQ  = "m";
  localparam logic [7:0] ChPg   = "P";
  localparam logic [7:0] ChPgQ  = "p";
  localparam logic [7:0] ChZero = "0";
  localparam logic [7:0] ChTwo  = "2";
  localparam logic [7:0] ChNine = "9";

  typedef enum logic [3:0] {
    ACT_ERROR   = 4'd0,
    ACT_STATUS  = 4'd1,
    ACT_DEBUG   = 4'd2,
    ACT_READ    = 4'd3,
    ACT_WRITE   = 4'd4,
    ACT_CHANNEL = 4'd5,
    ACT_UP      = 4'd6,
    ACT_DOWN    = 4'd7,
    ACT_MY      = 4'd8,
    ACT_PROG    = 4'd9,
    ACT_Q_UP    = 4'd10,
    ACT_Q_DOWN  = 4'd11,
    ACT_Q_MY    = 4'd12,
    ACT_Q_PROG  = 4'd13
  } action_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_UNKNOWN = 3'd1,
    ERR_SHORT   = 3'd2,
    ERR_LONG    = 3'd3,
    ERR_DATA    = 3'd4
  } error_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START   = 2'd0,
    CFG_END     = 2'd1,
    CFG_DEFAULT = 2'd2,
    CFG_QUICK   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_ACQUIRE
  } phase_e;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_DECODE,
    OP_ERROR
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EXAM
  } back_state_e;

  typedef enum logic [1:0] {
    KD_CMD,
    KD_CONFIG,
    KD_QUICK,
    KD_PULSE
  } kind_e;

  typedef struct packed {
    op_e             op;
    logic [PosW-1:0] pos;
    logic [7:0]      data;
    error_e          err;
  } job_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [2:0]        error_code;
    logic [DelayW-1:0] duration;
    logic [3:0]        target_channel;
    logic [1:0]        debug_level;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

FILE: src/fscd_if.sv
interface fscd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fscd_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [2:0]  error_code;
  logic [19:0] duration;
  logic [3:0]  target_channel;
  logic [1:0]  debug_level;

  modport source (output valid, output action, output error_code, output duration,
                  output target_channel, output debug_level, input ready);
  modport sink   (input valid, input action, input error_code, input duration,
                  input target_channel, input debug_level, output ready);
endinterface

FILE: src/fscd_front.sv
module fscd_front
  import fscd_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_marker_i,
  input  logic [7:0] end_marker_i,
  fscd_rx_if.sink    rx_i,
  output job_t       job_o,
  output logic       job_valid_o,
  input  logic       job_full_i
);

  localparam int LW = $clog2(MAX_FRAME + 1);

  phase_e          phase_q, phase_d;
  logic [LW-1:0]   len_q, len_d;
  logic            take;
  logic [7:0]      b;

  assign rx_i.ready = !job_full_i;
  assign take       = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    job_valid_o = 1'b0;
    job_o.op    = OP_STORE;
    job_o.pos   = PosW'(len_q);
    job_o.data  = b;
    job_o.err   = ERR_NONE;
    if (take && (b != 8'd0)) begin
      if (b == start_marker_i) begin
        phase_d = PH_START;
        len_d   = '0;
      end else if (b == end_marker_i) begin
        phase_d = PH_IDLE;
        case (phase_q)
          PH_ACQUIRE: begin
            job_valid_o = 1'b1;
            job_o.op    = OP_DECODE;
            len_d       = '0;
          end
          default: begin
            if (len_q != '0) begin
              job_valid_o = 1'b1;
              job_o.op    = OP_ERROR;
              job_o.err   = ERR_SHORT;
            end
          end
        endcase
      end else begin
        case (phase_q)
          PH_START, PH_ACQUIRE: begin
            if (len_q < LW'(MAX_FRAME)) begin
              job_valid_o = 1'b1;
              len_d       = len_q + LW'(1);
              phase_d     = PH_ACQUIRE;
            end else begin
              job_valid_o = 1'b1;
              job_o.op    = OP_ERROR;
              job_o.err   = ERR_LONG;
              phase_d     = PH_IDLE;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
    end
  end

endmodule

FILE: src/fscd_queue.sv
module fscd_queue
  import fscd_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/fscd_back.sv
module fscd_back
  import fscd_pkg::*;
#(
  parameter int MAX_FRAME = MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  logic        job_empty_i,
  output logic        job_pop_o,
  input  logic [15:0] default_delay_i,
  input  logic [15:0] quick_delay_i,
  fscd_res_if.source  res_o
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int LW = $clog2(MAX_FRAME + 1);

  back_state_e       state_q, state_d;
  kind_e             kind_q, kind_d;
  action_e           act_q, act_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     len_q, len_d;
  logic [DelayW-1:0] acc_q, acc_d;
  logic [1:0]        debug_q, debug_d;
  result_t           res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic [7:0]        store_q [MAX_FRAME];
  logic [7:0]        rd_q;
  logic              store_we;

  action_e           cmd_act;
  logic              cmd_pulse, cmd_quick;
  logic [7:0]        digit;
  logic [LW-1:0]     nxt;
  logic              more;
  logic [23:0]       prod;
  logic [DelayW-1:0] acc_sat;
  logic              emit;
  result_t           emit_res;

  function automatic result_t make_err(input error_e e, input logic [1:0] dbg);
    result_t r;
    r.action         = ACT_ERROR;
    r.error_code     = e;
    r.duration       = '0;
    r.target_channel = '0;
    r.debug_level    = dbg;
    return r;
  endfunction

  function automatic result_t make_act(input action_e a, input logic [DelayW-1:0] d,
                                       input logic [3:0] ch, input logic [1:0] dbg);
    result_t r;
    r.action         = a;
    r.error_code     = ERR_NONE;
    r.duration       = d;
    r.target_channel = ch;
    r.debug_level    = dbg;
    return r;
  endfunction

  assign store_we = job_pop_o && (job_i.op == OP_STORE);

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[job_i.pos[AW-1:0]] <= job_i.data;
    end
    rd_q <= store_q[idx_q];
  end

  always_comb begin
    case (rd_q)
      ChL:     cmd_act = ACT_CHANNEL;
      ChUp:    cmd_act = ACT_UP;
      ChDn:    cmd_act = ACT_DOWN;
      ChMy:    cmd_act = ACT_MY;
      ChPg:    cmd_act = ACT_PROG;
      ChUpQ:   cmd_act = ACT_Q_UP;
      ChDnQ:   cmd_act = ACT_Q_DOWN;
      ChMyQ:   cmd_act = ACT_Q_MY;
      ChPgQ:   cmd_act = ACT_Q_PROG;
      default: cmd_act = ACT_ERROR;
    endcase
  end

  assign cmd_quick = (cmd_act >= ACT_Q_UP);
  assign cmd_pulse = (cmd_act >= ACT_CHANNEL) && (cmd_act <= ACT_PROG);
  assign digit     = rd_q - ChZero;
  assign nxt       = LW'(idx_q) + LW'(1);
  assign more      = (nxt < len_q);
  assign prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 24'(digit[3:0]);
  assign acc_sat   = (prod > 24'(DelayCap)) ? DelayCap : prod[DelayW-1:0];

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    act_d       = act_q;
    idx_d       = idx_q;
    len_d       = len_q;
    acc_d       = acc_q;
    debug_d     = debug_q;
    job_pop_o   = 1'b0;
    emit        = 1'b0;
    emit_res    = make_err(ERR_NONE, debug_q);
    res_valid_d = res_valid_q && !res_o.ready;

    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          case (job_i.op)
            OP_STORE: job_pop_o = 1'b1;
            OP_ERROR: begin
              if (!res_valid_q) begin
                job_pop_o = 1'b1;
                emit      = 1'b1;
                emit_res  = make_err(job_i.err, debug_q);
              end
            end
            OP_DECODE: begin
              if (!res_valid_q) begin
                job_pop_o = 1'b1;
                len_d     = job_i.pos[LW-1:0];
                idx_d     = '0;
                kind_d    = KD_CMD;
                state_d   = BK_FETCH;
              end
            end
            default: job_pop_o = 1'b1;
          endcase
        end
      end

      BK_FETCH: state_d = BK_EXAM;

      BK_EXAM: begin
        state_d = BK_IDLE;
        case (kind_q)
          KD_CMD: begin
            if ((rd_q == ChS) || (rd_q == ChR)) begin
              emit = 1'b1;
              if (len_q > LW'(1)) begin
                emit_res = make_err(ERR_LONG, debug_q);
              end else begin
                emit_res = make_act((rd_q == ChS) ? ACT_STATUS : ACT_READ, '0, '0, debug_q);
              end
            end else if (rd_q == ChW) begin
              emit     = 1'b1;
              emit_res = make_act(ACT_WRITE, '0, '0, debug_q);
            end else if (rd_q == ChC) begin
              if (len_q > LW'(3)) begin
                emit     = 1'b1;
                emit_res = make_err(ERR_LONG, debug_q);
              end else if (len_q < LW'(3)) begin
                emit     = 1'b1;
                emit_res = make_err(ERR_SHORT, debug_q);
              end else begin
                kind_d  = KD_CONFIG;
                idx_d   = AW'(1);
                state_d = BK_FETCH;
              end
            end else if (cmd_pulse) begin
              act_d = cmd_act;
              if (len_q <= LW'(1)) begin
                emit     = 1'b1;
                emit_res = make_act(cmd_act, DelayW'(default_delay_i), '0, debug_q);
              end else begin
                acc_d   = '0;
                kind_d  = KD_PULSE;
                idx_d   = AW'(1);
                state_d = BK_FETCH;
              end
            end else if (cmd_quick) begin
              act_d = cmd_act;
              if (len_q > LW'(2)) begin
                emit     = 1'b1;
                emit_res = make_err(ERR_LONG, debug_q);
              end else if (len_q == LW'(2)) begin
                kind_d  = KD_QUICK;
                idx_d   = AW'(1);
                state_d = BK_FETCH;
              end else begin
                emit     = 1'b1;
                emit_res = make_act(cmd_act, DelayW'(quick_delay_i), '0, debug_q);
              end
            end else begin
              emit     = 1'b1;
              emit_res = make_err(ERR_UNKNOWN, debug_q);
            end
          end

          KD_CONFIG: begin
            if (idx_q == AW'(1)) begin
              if (rd_q == ChDn) begin
                idx_d   = AW'(2);
                state_d = BK_FETCH;
              end else begin
                emit     = 1'b1;
                emit_res = make_err(ERR_DATA, debug_q);
              end
            end else if ((rd_q >= ChZero) && (rd_q <= ChTwo)) begin
              debug_d  = digit[1:0];
              emit     = 1'b1;
              emit_res = make_act(ACT_DEBUG, '0, '0, digit[1:0]);
            end else begin
              emit     = 1'b1;
              emit_res = make_err(ERR_DATA, debug_q);
            end
          end

          KD_QUICK: begin
            emit = 1'b1;
            if (is_digit(rd_q)) begin
              emit_res = make_act(act_q, DelayW'(quick_delay_i), digit[3:0], debug_q);
            end else begin
              emit_res = make_err(ERR_DATA, debug_q);
            end
          end

          KD_PULSE: begin
            if (!is_digit(rd_q)) begin
              emit     = 1'b1;
              emit_res = make_err(ERR_DATA, debug_q);
            end else if (more) begin
              acc_d   = acc_sat;
              idx_d   = nxt[AW-1:0];
              state_d = BK_FETCH;
            end else begin
              emit     = 1'b1;
              emit_res = make_act(act_q, acc_sat, '0, debug_q);
            end
          end

          default: state_d = BK_IDLE;
        endcase
      end

      default: state_d = BK_IDLE;
    endcase

    res_d = res_q;
    if (emit) begin
      res_d       = emit_res;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      debug_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      debug_q     <= debug_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    act_q  <= act_d;
    idx_q  <= idx_d;
    len_q  <= len_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.action         = res_q.action;
  assign res_o.error_code     = res_q.error_code;
  assign res_o.duration       = res_q.duration;
  assign res_o.target_channel = res_q.target_channel;
  assign res_o.debug_level    = res_q.debug_level;

endmodule

FILE: src/framed_serial_command_decoder.sv
// Channel   Dir  Handshake          Word
// rx_i      in   valid/ready        rx_byte[7:0]
// res_o     out  valid/ready        action, error_code, duration, target_channel,
//                                   debug_level
// cfg       in   cfg_we_i only      cfg_idx_i[1:0], cfg_data_i[15:0]
//
// A byte is taken whenever the job queue has room.
// The back end pops stored byte and error jobs singly, and decodes a frame by
// alternating fetch and exam states, one frame-store read port walking the bytes.
// A result sits in an output register; the back end holds further decode and error
// jobs until it is taken, while stored bytes at the queue head keep draining.
// Reset is asynchronous, active low, and needs no clearing pass.
module framed_serial_command_decoder
  import fscd_pkg::*;
#(
  parameter int MAX_FRAME   = MaxFrameDef,
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fscd_rx_if.sink             rx_i,
  fscd_res_if.source          res_o
);

  logic [7:0]  start_q, end_q;
  logic [15:0] dflt_q, quick_q;

  job_t        push_job, head_job;
  logic        push_valid, q_full, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartMarkerRst;
      end_q   <= EndMarkerRst;
      dflt_q  <= DefaultDelayRst;
      quick_q <= QuickDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START:   start_q <= cfg_data_i[7:0];
        CFG_END:     end_q   <= cfg_data_i[7:0];
        CFG_DEFAULT: dflt_q  <= cfg_data_i;
        CFG_QUICK:   quick_q <= cfg_data_i;
        default:     start_q <= start_q;
      endcase
    end
  end

  fscd_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_marker_i (start_q),
    .end_marker_i   (end_q),
    .rx_i           (rx_i),
    .job_o          (push_job),
    .job_valid_o    (push_valid),
    .job_full_i     (q_full)
  );

  fscd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  fscd_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (head_job),
    .job_empty_i     (q_empty),
    .job_pop_o       (q_pop),
    .default_delay_i (dflt_q),
    .quick_delay_i   (quick_q),
    .res_o           (res_o)
  );

endmodule

FILE: src/fscd_checker.sv
module fscd_checker
  import fscd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [3:0]  action_i,
  input logic [2:0]  error_code_i,
  input logic [19:0] duration_i,
  input logic [3:0]  target_channel_i,
  input logic [1:0]  debug_level_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(action_i) &&
      $stable(error_code_i) && $stable(duration_i) && $stable(target_channel_i))
    else $error("result word changed while stalled");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((action_i == ACT_ERROR) == (error_code_i != ERR_NONE)))
    else $error("error code does not match action");

  a_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (target_channel_i != 4'd0) |->
      (action_i >= ACT_Q_UP) && (action_i <= ACT_Q_PROG) && (target_channel_i <= 4'd9))
    else $error("channel on a non-quick action");

  a_nodelay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (action_i <= ACT_WRITE) |-> (duration_i == 20'd0))
    else $error("delay on an action without one");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (debug_level_i != 2'd3) && (duration_i <= DelayCap))
    else $error("debug level or delay out of range");

endmodule

bind framed_serial_command_decoder fscd_checker u_fscd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .action_i         (res_o.action),
  .error_code_i     (res_o.error_code),
  .duration_i       (res_o.duration),
  .target_channel_i (res_o.target_channel),
  .debug_level_i    (res_o.debug_level)
);

FILE: tb/framed_serial_command_decoder_tb.sv
`timescale 1ns / 100ps

module framed_serial_command_decoder_tb;
  import fscd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 64;
  localparam int PhaseBytes  = 325;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  fscd_rx_if  rx_bus ();
  fscd_res_if res_bus ();

  framed_serial_command_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_bus),
    .res_o      (res_bus)
  );

  logic [7:0]  start_mk = StartMarkerRst;
  logic [7:0]  end_mk = EndMarkerRst;
  logic [15:0] dflt_delay = DefaultDelayRst;
  logic [15:0] quick_delay = QuickDelayRst;
  logic [7:0]  frame_buf [MaxFrameDef];
  int unsigned frame_len = 0;
  phase_e      rx_phase = PH_IDLE;
  logic [1:0]  dbg_lvl = 2'd0;

  result_t expected_q [$];
  int fail_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic result_t outcome(action_e a, error_e e, logic [19:0] d, logic [3:0] ch);
    result_t r;
    r.action = a;
    r.error_code = e;
    r.duration = d;
    r.target_channel = ch;
    r.debug_level = dbg_lvl;
    return r;
  endfunction

  function automatic result_t decode_frame_model();
    action_e a;
    int unsigned acc;
    int unsigned i;
    a = ACT_ERROR;
    case (frame_buf[0])
      ChS, ChR: begin
        if (frame_len > 1) return outcome(ACT_ERROR, ERR_LONG, 20'd0, 4'd0);
        return outcome(frame_buf[0] == ChS ? ACT_STATUS : ACT_READ, ERR_NONE, 20'd0, 4'd0);
      end
      ChW: return outcome(ACT_WRITE, ERR_NONE, 20'd0, 4'd0);
      ChC: begin
        if (frame_len > 3) return outcome(ACT_ERROR, ERR_LONG, 20'd0, 4'd0);
        if (frame_len < 3) return outcome(ACT_ERROR, ERR_SHORT, 20'd0, 4'd0);
        if (frame_buf[1] != ChDn) return outcome(ACT_ERROR, ERR_DATA, 20'd0, 4'd0);
        if (frame_buf[2] < ChZero || frame_buf[2] > ChTwo)
          return outcome(ACT_ERROR, ERR_DATA, 20'd0, 4'd0);
        dbg_lvl = 2'(frame_buf[2] - ChZero);
        return outcome(ACT_DEBUG, ERR_NONE, 20'd0, 4'd0);
      end
      ChL:   a = ACT_CHANNEL;
      ChUp:  a = ACT_UP;
      ChDn:  a = ACT_DOWN;
      ChMy:  a = ACT_MY;
      ChPg:  a = ACT_PROG;
      ChUpQ: a = ACT_Q_UP;
      ChDnQ: a = ACT_Q_DOWN;
      ChMyQ: a = ACT_Q_MY;
      ChPgQ: a = ACT_Q_PROG;
      default: return outcome(ACT_ERROR, ERR_UNKNOWN, 20'd0, 4'd0);
    endcase
    if (a >= ACT_Q_UP) begin
      if (frame_len > 2) return outcome(ACT_ERROR, ERR_LONG, 20'd0, 4'd0);
      if (frame_len == 2) begin
        if (frame_buf[1] < ChZero || frame_buf[1] > ChNine)
          return outcome(ACT_ERROR, ERR_DATA, 20'd0, 4'd0);
        return outcome(a, ERR_NONE, {4'd0, quick_delay}, 4'(frame_buf[1] - ChZero));
      end
      return outcome(a, ERR_NONE, {4'd0, quick_delay}, 4'd0);
    end
    if (frame_len <= 1) return outcome(a, ERR_NONE, {4'd0, dflt_delay}, 4'd0);
    acc = 0;
    for (i = 1; i < frame_len; i++) begin
      if (frame_buf[i] < ChZero || frame_buf[i] > ChNine)
        return outcome(ACT_ERROR, ERR_DATA, 20'd0, 4'd0);
      acc = acc * 10 + 32'(frame_buf[i] - ChZero);
      if (acc > 32'(DelayCap)) acc = 32'(DelayCap);
    end
    return outcome(a, ERR_NONE, acc[19:0], 4'd0);
  endfunction

  task automatic take_byte(input logic [7:0] b);
    if (b == 8'h00) return;
    if (b == start_mk) begin
      rx_phase = PH_START;
      frame_len = 0;
    end else if (b == end_mk) begin
      if (rx_phase == PH_ACQUIRE) begin
        expected_q.push_back(decode_frame_model());
        frame_len = 0;
      end else if (frame_len != 0) begin
        expected_q.push_back(outcome(ACT_ERROR, ERR_SHORT, 20'd0, 4'd0));
      end
      rx_phase = PH_IDLE;
    end else if (rx_phase != PH_IDLE) begin
      if (frame_len < MaxFrameDef) begin
        frame_buf[frame_len] = b;
        frame_len++;
        rx_phase = PH_ACQUIRE;
      end else begin
        rx_phase = PH_IDLE;
        expected_q.push_back(outcome(ACT_ERROR, ERR_LONG, 20'd0, 4'd0));
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      rx_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
    take_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] body [$]);
    send_byte(start_mk);
    foreach (body[k]) send_byte(body[k]);
    send_byte(end_mk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_START:   start_mk = v[7:0];
      CFG_END:     end_mk = v[7:0];
      CFG_DEFAULT: dflt_delay = v;
      CFG_QUICK:   quick_delay = v;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
                                input logic [15:0] dd, input logic [15:0] qd);
    write_reg(CFG_START, {8'($urandom), s});
    write_reg(CFG_END, {8'($urandom), e});
    write_reg(CFG_DEFAULT, dd);
    write_reg(CFG_QUICK, qd);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    rx_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 13))
      0:  return ChS;
      1:  return ChR;
      2:  return ChW;
      3:  return ChC;
      4:  return ChL;
      5:  return ChUp;
      6:  return ChDn;
      7:  return ChMy;
      8:  return ChPg;
      9:  return ChUpQ;
      10: return ChDnQ;
      11: return ChMyQ;
      12: return ChPgQ;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  task automatic test_idle_bytes_and_status();
    logic [7:0] body [$];
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(end_mk);
    body = {ChS};
    send_frame(body);
    body = {ChR, 8'h41};
    send_frame(body);
  endtask

  task automatic test_debug_level();
    logic [7:0] body [$];
    body = {ChC, ChDn, ChTwo};
    send_frame(body);
  endtask

  task automatic test_frame_overflow();
    logic [7:0] body [$];
    body = {ChW, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h33};
    send_byte(start_mk);
    foreach (body[k]) send_byte(body[k]);
    send_byte(end_mk);
  endtask

  task automatic test_pulse_max();
    logic [7:0] body [$];
    body = {ChUp, ChNine, ChNine, ChNine, ChNine, ChNine, ChNine};
    send_frame(body);
  endtask

  task automatic test_marker_clash();
    settle();
    apply_settings(8'h7E, 8'h7E, DefaultDelayRst, QuickDelayRst);
    send_byte(8'h7E);
    send_byte(ChS);
    send_byte(8'h7E);
  endtask

  task automatic test_traffic(input int src_pct, input int snk_pct,
                              input logic [7:0] s, input logic [7:0] e,
                              input logic [15:0] dd, input logic [15:0] qd);
    logic [7:0] pkt [$];
    logic [7:0] cmd;
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    settle();
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    apply_settings(s, e, dd, qd);
    sent = 0;
    while (sent < PhaseBytes) begin
      pkt.delete();
      if ($urandom_range(0, 99) < 85) begin
        cmd = pick_cmd();
        pkt.push_back(start_mk);
        pkt.push_back(cmd);
        case (cmd)
          ChS, ChR: if ($urandom_range(0, 3) == 0) pkt.push_back(8'($urandom));
          ChW: repeat ($urandom_range(0, 8)) pkt.push_back(8'($urandom));
          ChC: begin
            r = $urandom_range(0, 9);
            pkt.push_back(r == 2 ? 8'($urandom) : ChDn);
            if (r != 0) begin
              if (r == 3) pkt.push_back(ChZero + 8'($urandom_range(3, 9)));
              else if (r == 4) pkt.push_back(8'($urandom));
              else pkt.push_back(ChZero + 8'($urandom_range(0, 2)));
            end
            if (r == 1) pkt.push_back(ChZero + 8'($urandom_range(0, 9)));
          end
          ChUpQ, ChDnQ, ChMyQ, ChPgQ: begin
            n = $urandom_range(0, 6) == 0 ? 2 : $urandom_range(0, 1);
            repeat (n) pkt.push_back(pick_digit());
          end
          default: begin
            n = $urandom_range(0, 15) == 0 ? 7 : $urandom_range(0, 6);
            repeat (n) pkt.push_back(pick_digit());
          end
        endcase
        if ($urandom_range(0, 19) != 0) pkt.push_back(end_mk);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          r = $urandom_range(0, 7);
          pkt.push_back(r == 0 ? start_mk : r == 1 ? end_mk : r == 2 ? 8'h00 : 8'($urandom));
        end
      end
      foreach (pkt[k]) begin
        if ($urandom_range(0, 19) == 0) send_byte(8'h00);
        send_byte(pkt[k]);
      end
      sent += pkt.size();
    end
  endtask

  task automatic check_field(input string name, input logic [19:0] want,
                             input logic [19:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : check_results
    result_t want;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: action %0d, error_code %0d",
                 res_bus.action, res_bus.error_code);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("action", 20'(want.action), 20'(res_bus.action));
          check_field("error_code", 20'(want.error_code), 20'(res_bus.error_code));
          check_field("duration", want.duration, res_bus.duration);
          check_field("target_channel", 20'(want.target_channel), 20'(res_bus.target_channel));
          check_field("debug_level", 20'(want.debug_level), 20'(res_bus.debug_level));
        end
      end
      res_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  initial begin
    logic [7:0] rs;
    logic [7:0] re;
    rx_bus.valid <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_START;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes_and_status();
    test_debug_level();
    test_frame_overflow();
    test_pulse_max();
    test_marker_clash();

    test_traffic(0, 0, StartMarkerRst, EndMarkerRst, DefaultDelayRst, QuickDelayRst);
    test_traffic(77, 0, 8'hFF, 8'h01, 16'hFFFF, 16'h0000);
    test_traffic(0, 77, 8'h01, 8'hFF, 16'h0000, 16'hFFFF);
    rs = 8'($urandom_range(1, 255));
    do re = 8'($urandom_range(1, 255)); while (re == rs);
    test_traffic(12, 12, rs, re, 16'($urandom), 16'($urandom));

    settle();
    if (expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
src/fscd_pkg.sv
src/fscd_if.sv
src/fscd_front.sv
src/fscd_queue.sv
src/fscd_back.sv
src/framed_serial_command_decoder.sv
src/fscd_checker.sv
tb/framed_serial_command_decoder_tb.sv
